@@ rtl/http_chunked_body_decoder_assert.svh @@
// Assertion macros used by the chunked body decoder parser.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HCBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HCBD_NEVER(lbl, expr, msg) \
	`HCBD_ASSERT(lbl, !(expr), msg)
`else
`define HCBD_ASSERT(lbl, prop, msg)
`define HCBD_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/hcbd_pkg.sv @@
// Shared types, character codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none
package hcbd_pkg;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       message_end;
		logic       format_error;
	} hcbd_result_t;

	typedef struct packed {
		logic         emit;
		hcbd_result_t res;
	} hcbd_step_t;

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/hcbd_parser.sv @@
// Size line parser, payload counter and trailer skipper for one byte per step.
`timescale 1ns / 1ps
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"
module hcbd_parser import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic [7:0]       data_byte,
	input  wire logic             message_start,
	output hcbd_step_t            step
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_PAYLOAD,
		PH_SKIP,
		PH_TRAILER,
		PH_DONE,
		PH_ERROR
	} phase_t;

	localparam logic [1:0] SKIP_LEN = 2'd2;

	phase_t               phase_q, ph, phase_d;
	logic [SIZE_BITS-1:0] chunk_q, chunk, chunk_d;
	logic                 digit_seen_q, ds, ds_d;
	logic                 digits_closed_q, dc, dc_d;
	logic                 cr_pending_q, cr, cr_d;
	logic [1:0]           skip_q, sk, sk_d;
	logic [4:0]           hex;

	always_comb begin
		ph    = phase_q;
		chunk = chunk_q;
		ds    = digit_seen_q;
		dc    = digits_closed_q;
		cr    = cr_pending_q;
		sk    = skip_q;
		if (message_start) begin
			ph    = PH_SIZE;
			chunk = '0;
			ds    = 1'b0;
			dc    = 1'b0;
			cr    = 1'b0;
			sk    = 2'd0;
		end
		phase_d = ph;
		chunk_d = chunk;
		ds_d    = ds;
		dc_d    = dc;
		cr_d    = cr;
		sk_d    = sk;
		step    = '0;
		hex     = hex_decode(data_byte);
		unique case (ph)
			PH_SIZE: begin
				if (cr && data_byte == CHAR_LF) begin
					cr_d = 1'b0;
					if (!ds) begin
						phase_d                = PH_ERROR;
						step.emit              = 1'b1;
						step.res.format_error  = 1'b1;
					end else begin
						ds_d = 1'b0;
						dc_d = 1'b0;
						if (chunk == '0) begin
							phase_d = PH_TRAILER;
							sk_d    = SKIP_LEN;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end else begin
					cr_d = (data_byte == CHAR_CR);
					if (dc) begin
						dc_d = 1'b1;
					end else if (!ds && (data_byte == CHAR_SP || data_byte == CHAR_TAB)) begin
						ds_d = 1'b0;
					end else if (!hex[4]) begin
						dc_d = 1'b1;
					end else if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
						phase_d               = PH_ERROR;
						step.emit             = 1'b1;
						step.res.format_error = 1'b1;
					end else begin
						chunk_d = {chunk[SIZE_BITS-5:0], hex[3:0]};
						ds_d    = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				chunk_d                = chunk - SIZE_BITS'(1);
				step.emit              = 1'b1;
				step.res.payload_byte  = data_byte;
				step.res.byte_valid    = 1'b1;
				if (chunk_d == '0) begin
					phase_d = PH_SKIP;
					sk_d    = SKIP_LEN;
				end
			end
			PH_SKIP: begin
				sk_d = sk - 2'd1;
				if (sk_d == 2'd0) begin
					phase_d = PH_SIZE;
					chunk_d = '0;
					ds_d    = 1'b0;
					dc_d    = 1'b0;
					cr_d    = 1'b0;
				end
			end
			PH_TRAILER: begin
				sk_d = sk - 2'd1;
				if (sk_d == 2'd0) begin
					phase_d              = PH_DONE;
					step.emit            = 1'b1;
					step.res.message_end = 1'b1;
				end
			end
			default: begin
				phase_d = ph;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SIZE;
			chunk_q         <= '0;
			digit_seen_q    <= 1'b0;
			digits_closed_q <= 1'b0;
			cr_pending_q    <= 1'b0;
			skip_q          <= 2'd0;
		end else if (step_en) begin
			phase_q         <= phase_d;
			chunk_q         <= chunk_d;
			digit_seen_q    <= ds_d;
			digits_closed_q <= dc_d;
			cr_pending_q    <= cr_d;
			skip_q          <= sk_d;
		end
	end

	`HCBD_ASSERT(a_one_flag, (step.emit |-> $onehot({step.res.byte_valid, step.res.message_end, step.res.format_error})), "result carries other than one flag")
	`HCBD_ASSERT(a_err_sticks, ((step_en && step.res.format_error) |=> (phase_q == PH_ERROR)), "format error did not enter error phase")
	`HCBD_ASSERT(a_quiet_end, ((step_en && !message_start && (phase_q == PH_DONE || phase_q == PH_ERROR)) |-> !step.emit), "result after end or error")
	`HCBD_NEVER(a_skip_range, (skip_q == 2'd3), "skip count out of range")

endmodule
`default_nettype wire

@@ rtl/hcbd_out_reg.sv @@
// Result register in front of the master-side stream.
`timescale 1ns / 1ps
`default_nettype none
module hcbd_out_reg import hcbd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  hcbd_result_t res_in,
	output logic        free,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output hcbd_result_t res_s2
);

	logic valid_s2;

	assign free     = !valid_s2 || m_tready;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res_in;
		end
	end

endmodule
`default_nettype wire

@@ rtl/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked transfer body decoder.
// Usage:
//   The body arrives on the s_axis channel one byte per transfer; tuser bit 0 marks the
//   first byte of a new body and restarts the parser before that byte is taken.
//   Results leave on the m_axis channel: a decoded payload byte, the end marker after the
//   terminating zero-size chunk and its two trailing bytes, or a format error for a size
//   line without hex digits or a size that does not fit in SIZE_BITS bits.
//   Bytes that only steer the parser (size lines, line ends, trailer) produce no transfer.
//   After an end marker or an error all bytes are dropped until the next start mark.
//   Throughput is one byte per cycle while the receiver does not stall, set by the single
//   parse step between the input register and the result register.
//   When the receiver stalls, the result register holds its transfer and the input
//   register fills, after which s_axis_tready drops; nothing is lost.
//   Reset clears both registers and returns the parser to the start of a size line.
`timescale 1ns / 1ps
`default_nettype none
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic [0:0] s_axis_tuser,  // [0] message_start
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] payload_byte
	output logic [2:0]      m_axis_tuser   // [0] byte_valid, [1] message_end, [2] format_error
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         start_s1;
	logic         out_free;
	logic         advance;
	hcbd_step_t   step;
	hcbd_result_t res_s2;

	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
		end
	end

	hcbd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.data_byte    (data_s1),
		.message_start(start_s1),
		.step         (step)
	);

	hcbd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && step.emit),
		.res_in  (step.res),
		.free    (out_free),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.res_s2  (res_s2)
	);

	assign m_axis_tdata = res_s2.payload_byte;
	assign m_axis_tuser = {res_s2.format_error, res_s2.message_end, res_s2.byte_valid};

endmodule
`default_nettype wire
